@@ rtl/u8esc_pkg.sv @@
// Shared types, constants and helper functions for the UTF-8 escaped text converter.
package u8esc_pkg;

   localparam int SLOT_COUNT  = 8;
   localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] MODE_MARK = 8'h01;
   localparam logic [7:0] QUESTION  = 8'h3f;
   localparam logic [7:0] COMMA     = 8'h2c;

   localparam logic [20:0] CP_MIN2     = 21'h000080;
   localparam logic [20:0] CP_MIN3     = 21'h000800;
   localparam logic [20:0] CP_MIN4     = 21'h010000;
   localparam logic [20:0] CP_SURR_LO  = 21'h00d800;
   localparam logic [20:0] CP_SURR_HI  = 21'h00dfff;
   localparam logic [20:0] CP_MAX      = 21'h10ffff;
   localparam logic [20:0] CP_WIDE_MAX = 21'h00ffff;
   localparam logic [20:0] CP_RAW_MAX  = 21'h0000ff;

   typedef struct packed {
      logic [SLOT_COUNT-1:0][7:0] data;
      logic [CNT_W-1:0]           count;
      logic                       text_last;
   } entry_type;

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return 8'h30 + {4'b0000, v};
      end
      return 8'h57 + {4'b0000, v};
   endfunction

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      if (b[7:5] == 3'b110) begin
         return 3'd2;
      end
      if (b[7:4] == 4'b1110) begin
         return 3'd3;
      end
      if (b[7:3] == 5'b11110) begin
         return 3'd4;
      end
      return 3'd0;
   endfunction

endpackage

@@ rtl/u8esc_req_if.sv @@
// Input channel carrying one text byte and its end flag.
interface u8esc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_end;

   modport source (output valid, output in_byte, output in_end, input ready);
   modport sink (input valid, input in_byte, input in_end, output ready);
endinterface

@@ rtl/u8esc_rsp_if.sv @@
// Result channel carrying one converted byte and its run and text end flags.
interface u8esc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       text_end;

   modport source (output valid, output out_byte, output run_end, output text_end, input ready);
   modport sink (input valid, input out_byte, input run_end, input text_end, output ready);
endinterface

@@ rtl/utf8_to_mode_escaped_text_unit.sv @@
// Top level of the UTF-8 to mode-escaped text converter.
// The result bytes of an accepted input byte pass through the queue and then the serializer register.
// Throughput: one input byte per cycle while each yields at most one result byte and the
// result channel is ready; otherwise the serializer sends its N result bytes (1 to 7).
// Reset: synchronous, clears wide mode, held sequence count, queue and serializer.
module utf8_to_mode_escaped_text_unit import u8esc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   u8esc_req_if.sink   req_chan,
   u8esc_rsp_if.source rsp_chan
);

   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_nonempty;
   entry_type q_push_entry;
   entry_type q_head;

   u8esc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_push_entry)
   );

   u8esc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .nonempty   (q_nonempty),
      .head       (q_head)
   );

   u8esc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_nonempty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ rtl/u8esc_front.sv @@
// Front end: decodes UTF-8 per byte and builds the escaped result bytes of each transaction.
module u8esc_front import u8esc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   u8esc_req_if.sink  req_chan,
   input  logic       q_full,
   output logic       q_push,
   output entry_type  q_entry
);

   logic             wide_ff, wide_in;
   logic [1:0]       held_cnt_ff, held_cnt_in;
   logic [2:0]       seq_len_ff, seq_len_in;
   logic [7:0]       held_ff [3];
   logic             hold_wr;
   logic [1:0]       hold_idx;

   logic             fire;
   logic [7:0]       b;
   logic             idle;
   logic             is_cont;
   logic             finishing;
   logic [2:0]       b_len;
   logic [20:0]      seq_cp;
   logic             seq_ok;
   logic [1:0]       raw_n;
   logic [7:0]       raw_v [3];
   logic             fin_en;
   logic [20:0]      fin_cp;
   logic [CNT_W-1:0] pos;
   logic             w;

   assign b              = req_chan.in_byte;
   assign req_chan.ready = !q_full;
   assign fire           = req_chan.valid && !q_full;
   assign idle           = (seq_len_ff == 3'd0) || (held_cnt_ff == 2'd0);
   assign is_cont        = (b[7:6] == 2'b10);
   assign b_len          = lead_len(b);
   assign finishing      = (({1'b0, held_cnt_ff} + 3'd1) >= seq_len_ff);

   always_comb begin
      case (seq_len_ff)
         3'd2: begin
            seq_cp = {10'd0, held_ff[0][4:0], b[5:0]};
            seq_ok = (seq_cp >= CP_MIN2);
         end
         3'd3: begin
            seq_cp = {5'd0, held_ff[0][3:0], held_ff[1][5:0], b[5:0]};
            seq_ok = (seq_cp >= CP_MIN3) && !((seq_cp >= CP_SURR_LO) && (seq_cp <= CP_SURR_HI));
         end
         default: begin
            seq_cp = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0], b[5:0]};
            seq_ok = (seq_cp >= CP_MIN4) && (seq_cp <= CP_MAX);
         end
      endcase
   end

   always_comb begin
      raw_n       = 2'd0;
      raw_v[0]    = held_ff[0];
      raw_v[1]    = held_ff[1];
      raw_v[2]    = held_ff[2];
      fin_en      = 1'b0;
      fin_cp      = {13'd0, b};
      held_cnt_in = 2'd0;
      seq_len_in  = 3'd0;
      hold_wr     = 1'b0;
      hold_idx    = 2'd0;
      if (idle) begin
         if ((b_len != 3'd0) && !req_chan.in_end) begin
            hold_wr     = 1'b1;
            held_cnt_in = 2'd1;
            seq_len_in  = b_len;
         end else begin
            fin_en = 1'b1;
         end
      end else if (is_cont) begin
         if (finishing) begin
            fin_en = 1'b1;
            if (seq_ok) begin
               fin_cp = seq_cp;
            end else begin
               raw_n = held_cnt_ff;
            end
         end else if (held_cnt_ff != 2'd3) begin
            if (req_chan.in_end) begin
               raw_n                = held_cnt_ff + 2'd1;
               raw_v[held_cnt_ff]   = b;
            end else begin
               hold_wr     = 1'b1;
               hold_idx    = held_cnt_ff;
               held_cnt_in = held_cnt_ff + 2'd1;
               seq_len_in  = seq_len_ff;
            end
         end else begin
            raw_n  = held_cnt_ff;
            fin_en = 1'b1;
         end
      end else begin
         raw_n = held_cnt_ff;
         if ((b_len != 3'd0) && !req_chan.in_end) begin
            hold_wr     = 1'b1;
            held_cnt_in = 2'd1;
            seq_len_in  = b_len;
         end else begin
            fin_en = 1'b1;
         end
      end
   end

   always_comb begin
      q_entry.data = '0;
      pos          = '0;
      w            = wide_ff;
      if ((raw_n != 2'd0) && w) begin
         q_entry.data[pos[2:0]] = MODE_MARK;
         pos                    = pos + 1'b1;
         w                      = 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         if (i < raw_n) begin
            q_entry.data[pos[2:0]] = raw_v[i];
            pos                    = pos + 1'b1;
         end
      end
      if (fin_en) begin
         if (fin_cp > CP_WIDE_MAX) begin
            if (w) begin
               q_entry.data[pos[2:0]] = MODE_MARK;
               pos                    = pos + 1'b1;
               w                      = 1'b0;
            end
            q_entry.data[pos[2:0]] = QUESTION;
            pos                    = pos + 1'b1;
         end else if (fin_cp > CP_RAW_MAX) begin
            if (!w) begin
               q_entry.data[pos[2:0]] = MODE_MARK;
               pos                    = pos + 1'b1;
               w                      = 1'b1;
            end
            q_entry.data[pos[2:0]] = COMMA;
            pos                    = pos + 1'b1;
            q_entry.data[pos[2:0]] = hex_char(fin_cp[15:12]);
            pos                    = pos + 1'b1;
            q_entry.data[pos[2:0]] = hex_char(fin_cp[11:8]);
            pos                    = pos + 1'b1;
            q_entry.data[pos[2:0]] = hex_char(fin_cp[7:4]);
            pos                    = pos + 1'b1;
            q_entry.data[pos[2:0]] = hex_char(fin_cp[3:0]);
            pos                    = pos + 1'b1;
         end else begin
            if (w) begin
               q_entry.data[pos[2:0]] = MODE_MARK;
               pos                    = pos + 1'b1;
               w                      = 1'b0;
            end
            q_entry.data[pos[2:0]] = fin_cp[7:0];
            pos                    = pos + 1'b1;
         end
      end
      if (req_chan.in_end && w) begin
         q_entry.data[pos[2:0]] = MODE_MARK;
         pos                    = pos + 1'b1;
         w                      = 1'b0;
      end
      q_entry.count     = pos;
      q_entry.text_last = req_chan.in_end;
      wide_in           = w;
   end

   assign q_push = fire && (pos != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff     <= 1'b0;
         held_cnt_ff <= 2'd0;
         seq_len_ff  <= 3'd0;
      end else if (fire) begin
         wide_ff     <= wide_in;
         held_cnt_ff <= held_cnt_in;
         seq_len_ff  <= seq_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && hold_wr) begin
         held_ff[hold_idx] <= b;
      end
   end

   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      (fire && req_chan.in_end) |-> q_push)
      else $error("final byte produced no result");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && req_chan.in_end) |=> (!wide_ff && (held_cnt_ff == 2'd0) && (seq_len_ff == 3'd0)))
      else $error("state not cleared after final byte");

endmodule

@@ rtl/u8esc_queue.sv @@
// Short queue between the decoder front end and the result serializer.
module u8esc_queue import u8esc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      nonempty,
   output entry_type head
);

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");

endmodule

@@ rtl/u8esc_back.sv @@
// Back end: serializes the queued result bytes of each transaction onto the result channel.
module u8esc_back import u8esc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  entry_type   q_head,
   output logic        q_pop,
   u8esc_rsp_if.source rsp_chan
);

   logic [SLOT_COUNT-1:0][7:0] data_ff, data_in;
   logic [CNT_W-1:0]           rem_ff;
   logic                       text_ff;
   logic                       take;
   logic                       load;

   assign rsp_chan.valid    = (rem_ff != '0);
   assign rsp_chan.out_byte = data_ff[0];
   assign rsp_chan.run_end  = (rem_ff == CNT_W'(1));
   assign rsp_chan.text_end = (rem_ff == CNT_W'(1)) && text_ff;

   assign take  = rsp_chan.valid && rsp_chan.ready;
   assign load  = q_valid && ((rem_ff == '0) || (take && (rem_ff == CNT_W'(1))));
   assign q_pop = load;

   always_comb begin
      for (int i = 0; i < SLOT_COUNT - 1; i++) begin
         data_in[i] = data_ff[i + 1];
      end
      data_in[SLOT_COUNT-1] = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (load) begin
         rem_ff <= q_head.count;
      end else if (take) begin
         rem_ff <= rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= q_head.data;
         text_ff <= q_head.text_last;
      end else if (take) begin
         data_ff <= data_in;
      end
   end

   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      load |=> (rem_ff != '0))
      else $error("loaded transaction holds no bytes");

endmodule

@@ verif/testbench.sv @@
// Testbench for the UTF-8 to mode-escaped text converter: directed and random byte streams.
module testbench import u8esc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       run_end;
      logic       text_end;
   } text_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   u8esc_req_if req_if ();
   u8esc_rsp_if rsp_if ();

   utf8_to_mode_escaped_text_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   text_out_type expected_text[$];
   logic [7:0]   step_out[$];
   logic         wide_open;
   logic [7:0]   held_seq[3];
   int           held_n;
   int           seq_len;
   bit           idle_on = 1'b1;
   int           fail_count = 0;
   int           bytes_sent = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Prediction of the converter.
   function void push_code(logic [20:0] cp);
      logic [3:0] nib;
      if (cp > CP_WIDE_MAX) begin
         if (wide_open) begin
            step_out.push_back(MODE_MARK);
            wide_open = 1'b0;
         end
         step_out.push_back(QUESTION);
      end else if (cp > CP_RAW_MAX) begin
         if (!wide_open) begin
            step_out.push_back(MODE_MARK);
            wide_open = 1'b1;
         end
         step_out.push_back(COMMA);
         for (int s = 12; s >= 0; s -= 4) begin
            nib = cp[s +: 4];
            step_out.push_back(nib < 4'd10 ? 8'h30 + {4'h0, nib} : 8'h61 + {4'h0, nib} - 8'd10);
         end
      end else begin
         if (wide_open) begin
            step_out.push_back(MODE_MARK);
            wide_open = 1'b0;
         end
         step_out.push_back(cp[7:0]);
      end
   endfunction

   function void flush_held();
      for (int i = 0; i < held_n; i++) push_code({13'd0, held_seq[i]});
      held_n  = 0;
      seq_len = 0;
   endfunction

   function void start_seq(logic [7:0] b);
      casez (b)
         8'b110?????: seq_len = 2;
         8'b1110????: seq_len = 3;
         8'b11110???: seq_len = 4;
         default:     seq_len = 0;
      endcase
      if (seq_len == 0) begin
         push_code({13'd0, b});
      end else begin
         held_seq[0] = b;
         held_n      = 1;
      end
   endfunction

   function void close_seq(logic [7:0] last);
      logic [20:0] cp;
      logic        ok;
      case (seq_len)
         2: begin
            cp = {10'd0, held_seq[0][4:0], last[5:0]};
            ok = cp >= CP_MIN2;
         end
         3: begin
            cp = {5'd0, held_seq[0][3:0], held_seq[1][5:0], last[5:0]};
            ok = cp >= CP_MIN3 && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
         end
         default: begin
            cp = {held_seq[0][2:0], held_seq[1][5:0], held_seq[2][5:0], last[5:0]};
            ok = cp >= CP_MIN4 && cp <= CP_MAX;
         end
      endcase
      if (ok) begin
         held_n  = 0;
         seq_len = 0;
         push_code(cp);
      end else begin
         flush_held();
         push_code({13'd0, last});
      end
   endfunction

   function void predict_text(logic [7:0] b, logic e);
      int last_k;
      step_out.delete();
      if (seq_len == 0 || held_n == 0) begin
         held_n  = 0;
         seq_len = 0;
         start_seq(b);
      end else if (b[7:6] == 2'b10) begin
         if (held_n + 1 >= seq_len) begin
            close_seq(b);
         end else begin
            held_seq[held_n] = b;
            held_n++;
         end
      end else begin
         flush_held();
         start_seq(b);
      end
      if (e) begin
         flush_held();
         if (wide_open) begin
            step_out.push_back(MODE_MARK);
            wide_open = 1'b0;
         end
      end
      last_k = step_out.size() - 1;
      foreach (step_out[k]) begin
         expected_text.push_back('{step_out[k], k == last_k, e && k == last_k});
      end
   endfunction

   function logic [31:0] utf8_word(int n, logic [20:0] cp);
      case (n)
         2:       return {16'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
         3:       return {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
         default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      endcase
   endfunction

   // Drive one byte and hold it until the transaction completes.
   task send_text_byte(logic [7:0] b, logic e);
      int gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.valid   = 1'b1;
      req_if.in_byte = b;
      req_if.in_end  = e;
      do @(posedge clock); while (!req_if.ready);
      predict_text(b, e);
      bytes_sent++;
   endtask

   task send_seq(int n, logic [31:0] word, logic end_last);
      for (int i = n - 1; i >= 0; i--) send_text_byte(word[8*i +: 8], end_last && i == 0);
   endtask

   task report_mismatch(string what, logic [7:0] want, logic [7:0] got);
      $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
      fail_count++;
   endtask

   // Result side: stall at random, then check each transaction.
   initial begin
      text_out_type want;
      int           stall;
      rsp_if.ready = 1'b0;
      wait (!reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 11) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_if.ready = 1'b0;
         end
         @(negedge clock);
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (expected_text.size() == 0) begin
            report_mismatch("unexpected out_byte", 8'h00, rsp_if.out_byte);
         end else begin
            want = expected_text.pop_front();
            if (rsp_if.out_byte !== want.data)
               report_mismatch("out_byte", want.data, rsp_if.out_byte);
            if (rsp_if.run_end !== want.run_end)
               report_mismatch("run_end", want.run_end, rsp_if.run_end);
            if (rsp_if.text_end !== want.text_end)
               report_mismatch("text_end", want.text_end, rsp_if.text_end);
         end
      end
   end

   task test_ascii_and_invalid();
      send_seq(1, 32'h0000_0001, 1'b0);
      send_seq(1, 32'h0000_007f, 1'b0);
      send_seq(2, 32'h0000_80bf, 1'b0);
      send_seq(1, 32'h0000_00ff, 1'b1);
   endtask

   task test_two_byte();
      send_seq(2, 32'h0000_c480, 1'b0);
      send_seq(2, 32'h0000_c3bf, 1'b0);
      send_seq(2, 32'h0000_c0af, 1'b1);
   endtask

   task test_three_byte();
      send_seq(3, 32'h00ef_bfbf, 1'b0);
      send_seq(3, 32'h00ed_a080, 1'b1);
   endtask

   task test_four_byte();
      send_seq(4, 32'hf48fbfbf, 1'b0);
      send_seq(4, 32'hf4908080, 1'b1);
   endtask

   task test_broken_text();
      send_seq(2, 32'h0000_e241, 1'b0);
      send_seq(1, 32'h0000_00f0, 1'b1);
      send_seq(2, 32'h0000_c480, 1'b1);
   endtask

   task test_random_text();
      int          start;
      int          kind;
      int          n;
      int          k;
      logic        e;
      logic [31:0] word;
      start = bytes_sent;
      while (bytes_sent - start < 470) begin
         if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
         kind = $urandom_range(0, 99);
         e    = ($urandom_range(0, 11) == 0);
         if (kind < 15) begin
            send_seq(1, $urandom_range(1, 127), e);
         end else if (kind < 30) begin
            send_seq(2, utf8_word(2, 21'($urandom_range(21'h80, 21'h7ff))), e);
         end else if (kind < 45) begin
            send_seq(3, utf8_word(3, 21'($urandom_range(21'h800, 21'hffff))), e);
         end else if (kind < 55) begin
            send_seq(4, utf8_word(4, 21'($urandom_range(21'h10000, 21'h10ffff))), e);
         end else if (kind < 70) begin
            n = $urandom_range(2, 4);
            send_seq(n, utf8_word(n, 21'($urandom)), e);
         end else if (kind < 82) begin
            // cut a sequence short, by the end of text or by a non-continuation byte
            n    = $urandom_range(2, 4);
            k    = $urandom_range(1, n - 1);
            word = utf8_word(n, 21'($urandom)) >> (8 * (n - k));
            if ($urandom_range(0, 1) == 0) begin
               send_seq(k, word, 1'b1);
            end else begin
               send_seq(k, word, 1'b0);
               send_seq(1, $urandom_range(0, 1) ? $urandom_range(1, 127)
                                                : $urandom_range(192, 255), e);
            end
         end else begin
            send_seq(1, $urandom_range(1, 255), e);
         end
      end
      send_seq(1, 32'h0000_0041, 1'b1);
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.in_byte = 8'h00;
      req_if.in_end  = 1'b0;
      wide_open      = 1'b0;
      held_n         = 0;
      seq_len        = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_ascii_and_invalid();
      test_two_byte();
      test_three_byte();
      test_four_byte();
      test_broken_text();
      test_random_text();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/u8esc_pkg.sv
rtl/u8esc_req_if.sv
rtl/u8esc_rsp_if.sv
rtl/u8esc_front.sv
rtl/u8esc_queue.sv
rtl/u8esc_back.sv
rtl/utf8_to_mode_escaped_text_unit.sv
verif/testbench.sv
